// ===== rtl/bdpl_pkg.sv =====
// Shared types and constants for the button debounce block.
package bdpl_pkg;

  localparam int unsigned KEY_W   = 8;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned CFG_W   = 16;

  localparam logic [KEY_W-1:0]   ENABLE_MASK_RESET = 8'hFF;
  localparam logic [DELAY_W-1:0] LONG_DELAY_RESET  = 16'd100;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_PRESS   = 2'd1,
    OP_LONG    = 2'd2,
    OP_RELEASE = 2'd3
  } bdpl_op_t;

  typedef enum logic {
    CFG_ENABLE_MASK = 1'b0,
    CFG_LONG_DELAY  = 1'b1
  } bdpl_cfg_idx_t;

  typedef struct packed {
    bdpl_op_t          operation;
    logic [KEY_W-1:0]  raw_pins;
    logic [KEY_W-1:0]  query_mask;
  } bdpl_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]  answer_keys;
    logic [KEY_W-1:0]  debounced_keys;
  } bdpl_result_t;

  typedef struct packed {
    logic [KEY_W-1:0]   enable_mask;
    logic [DELAY_W-1:0] long_delay;
  } bdpl_cfg_t;

endpackage

// ===== rtl/bdpl_core.sv =====
// Key state: vertical-counter debounce, press/long/release flags and the repeat counter.
module bdpl_core import bdpl_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         item_fire,
  input  bdpl_item_t   item,
  input  bdpl_cfg_t    cfg,
  output bdpl_result_t result
);

  logic               phase_r,    phase_nxt;
  logic [KEY_W-1:0]   cnt_lo_r,   cnt_lo_nxt;
  logic [KEY_W-1:0]   cnt_hi_r,   cnt_hi_nxt;
  logic [KEY_W-1:0]   stable_r,   stable_nxt;
  logic [KEY_W-1:0]   press_r,    press_nxt;
  logic [KEY_W-1:0]   long_r,     long_nxt;
  logic [KEY_W-1:0]   latch_r,    latch_nxt;
  logic [DELAY_W-1:0] repeat_r,   repeat_nxt;
  logic               all_rel_r,  all_rel_nxt;

  // debounce step terms
  logic [KEY_W-1:0]   held, diff, flip, db_lo, db_hi, db_stable;
  logic [DELAY_W-1:0] rep_base, rep_dec;
  logic               rel_base;
  logic [KEY_W-1:0]   answer;
  logic               rel_hit;

  always_comb begin
    held      = ~item.raw_pins & cfg.enable_mask;
    diff      = stable_r ^ held;
    db_lo     = ~(cnt_lo_r & diff);
    db_hi     = db_lo ^ (cnt_hi_r & diff);
    flip      = diff & db_lo & db_hi;
    db_stable = stable_r ^ flip;
    // reload while nothing is held, then count down with wrap
    rep_base  = (db_stable == '0) ? cfg.long_delay : repeat_r;
    rel_base  = (db_stable == '0) ? 1'b1 : all_rel_r;
    rep_dec   = rep_base - DELAY_W'(1);
    rel_hit   = ((latch_r & item.query_mask) != '0) && ((stable_r & item.query_mask) == '0);
  end

  always_comb begin
    phase_nxt   = phase_r;
    cnt_lo_nxt  = cnt_lo_r;
    cnt_hi_nxt  = cnt_hi_r;
    stable_nxt  = stable_r;
    press_nxt   = press_r;
    long_nxt    = long_r;
    latch_nxt   = latch_r;
    repeat_nxt  = repeat_r;
    all_rel_nxt = all_rel_r;
    answer      = '0;
    unique case (item.operation)
      OP_TICK: begin
        phase_nxt = ~phase_r;
        if (!phase_r) begin
          cnt_lo_nxt  = db_lo;
          cnt_hi_nxt  = db_hi;
          stable_nxt  = db_stable;
          press_nxt   = press_r | (db_stable & flip);
          repeat_nxt  = rep_dec;
          all_rel_nxt = rel_base;
          if ((rep_dec == '0) && rel_base) begin
            long_nxt    = long_r | db_stable;
            all_rel_nxt = 1'b0;
          end
        end
      end
      OP_PRESS: begin
        answer = item.query_mask & press_r;
        if (answer != '0) begin
          latch_nxt = answer;
          press_nxt = press_r & ~answer;
        end
      end
      OP_LONG: begin
        answer   = item.query_mask & long_r;
        long_nxt = long_r & ~answer;
      end
      OP_RELEASE: begin
        if (rel_hit) begin
          latch_nxt = latch_r & ~item.query_mask;
          answer    = KEY_W'(1);
        end
      end
      default: answer = '0;
    endcase
  end

  assign result.answer_keys    = answer;
  assign result.debounced_keys = stable_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= 1'b0;
      cnt_lo_r  <= '0;
      cnt_hi_r  <= '0;
      stable_r  <= '0;
      press_r   <= '0;
      long_r    <= '0;
      latch_r   <= '0;
      repeat_r  <= '0;
      all_rel_r <= 1'b0;
    end else if (item_fire) begin
      phase_r   <= phase_nxt;
      cnt_lo_r  <= cnt_lo_nxt;
      cnt_hi_r  <= cnt_hi_nxt;
      stable_r  <= stable_nxt;
      press_r   <= press_nxt;
      long_r    <= long_nxt;
      latch_r   <= latch_nxt;
      repeat_r  <= repeat_nxt;
      all_rel_r <= all_rel_nxt;
    end
  end

  a_release_is_bit : assert property (@(posedge clk) disable iff (!rst_n)
    (item_fire && item.operation == OP_RELEASE) |-> (result.answer_keys[KEY_W-1:1] == '0))
    else $error("release answer wider than one bit");

  a_press_cleared : assert property (@(posedge clk) disable iff (!rst_n)
    (item_fire && item.operation == OP_PRESS) |=> ((press_r & $past(result.answer_keys)) == '0))
    else $error("press flags not cleared after read");

  a_tick_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (item_fire && item.operation == OP_TICK) |-> (result.answer_keys == '0))
    else $error("tick returned a nonzero answer");

  a_idle_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !item_fire |=> ($stable(stable_r) && $stable(repeat_r) && $stable(latch_r)))
    else $error("key state changed without a transfer");

endmodule

// ===== rtl/button_debounce_press_long_release.sv =====
// Top level: input register, key state core, result register and configuration registers.
//
//   port group | direction | transfer when
//   in_*       | in        | in_valid && !in_stall
//   out_*      | out       | out_valid && !out_stall
//   cfg_*      | in        | cfg_we
//
// One item per cycle sustained while out_stall is low; an item passes the input register, then
// the key state logic and the result register; out_stall can hold it in the input register.
// Synchronous active-low reset clears the key state and restores the configuration defaults.
// out_stall backs up into in_stall the same cycle only when both registers are full.
module button_debounce_press_long_release import bdpl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [KEY_W-1:0]   in_raw_pins,
  input  logic [KEY_W-1:0]   in_query_mask,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KEY_W-1:0]   out_answer_keys,
  output logic [KEY_W-1:0]   out_debounced_keys,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  bdpl_cfg_t    cfg_r;
  bdpl_item_t   item_r;
  logic         item_v_r;
  bdpl_result_t res_r;
  logic         out_v_r;
  bdpl_result_t res_nxt;
  logic         out_ready, item_fire, in_take;

  assign out_ready = !out_v_r || !out_stall;
  assign item_fire = item_v_r && out_ready;
  assign in_stall  = item_v_r && !out_ready;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_mask <= ENABLE_MASK_RESET;
      cfg_r.long_delay  <= LONG_DELAY_RESET;
    end else if (cfg_we) begin
      unique case (bdpl_cfg_idx_t'(cfg_index))
        CFG_ENABLE_MASK: cfg_r.enable_mask <= cfg_wdata[KEY_W-1:0];
        CFG_LONG_DELAY:  cfg_r.long_delay  <= cfg_wdata[DELAY_W-1:0];
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (in_take) begin
        item_v_r <= 1'b1;
      end else if (item_fire) begin
        item_v_r <= 1'b0;
      end
      if (item_fire) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.operation  <= bdpl_op_t'(in_operation);
      item_r.raw_pins   <= in_raw_pins;
      item_r.query_mask <= in_query_mask;
    end
    if (item_fire) begin
      res_r <= res_nxt;
    end
  end

  bdpl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (item_fire),
    .item      (item_r),
    .cfg       (cfg_r),
    .result    (res_nxt)
  );

  assign out_valid          = out_v_r;
  assign out_answer_keys    = res_r.answer_keys;
  assign out_debounced_keys = res_r.debounced_keys;

  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (item_v_r && out_v_r))
    else $error("input stalled with room in the pipeline");

  a_item_held : assert property (@(posedge clk) disable iff (!rst_n)
    (item_v_r && !out_ready) |=> (item_v_r && $stable(item_r)))
    else $error("pending item lost while output stalled");

  a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(item_v_r))
    else $error("result appeared without an item");

endmodule
